// ===== sv/lcdsw_pkg.sv =====
// ============================================================================
// lcdsw_pkg
// Shared types and constants for the display refresh sequencer: bus command
// codes, sequence steps, display bytes and the command bundle that travels
// from the front end to the back end.
// ============================================================================
`default_nettype none

package lcdsw_pkg;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_RSTART = 3'd1,
        CMD_SEND   = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_WAIT   = 3'd4
    } cmd_t;

    typedef logic [5:0] step_t;

    // refresh sequence
    localparam step_t STEP_START      = 6'd0;
    localparam step_t STEP_ADDR_A     = 6'd1;
    localparam step_t STEP_CTL_A      = 6'd2;
    localparam step_t STEP_CTL_B      = 6'd3;
    localparam step_t STEP_DATA_A     = 6'd4;
    localparam step_t STEP_LINE_ONE   = 6'd5;
    localparam step_t STEP_LINE_THREE = 6'd6;
    localparam step_t STEP_RSTART     = 6'd7;
    localparam step_t STEP_ADDR_B     = 6'd8;
    localparam step_t STEP_CTL_C      = 6'd9;
    localparam step_t STEP_ROW_TWO    = 6'd10;
    localparam step_t STEP_DATA_B     = 6'd11;
    localparam step_t STEP_LINE_TWO   = 6'd12;
    localparam step_t STEP_LINE_FOUR  = 6'd13;
    localparam step_t STEP_STOP       = 6'd14;
    // power-up sequence
    localparam step_t STEP_INIT       = 6'd17;
    localparam step_t STEP_I_ADDR_1   = 6'd18;
    localparam step_t STEP_I_CTL_1    = 6'd19;
    localparam step_t STEP_I_FUNC     = 6'd20;
    localparam step_t STEP_I_GAP_1    = 6'd21;
    localparam step_t STEP_I_ADDR_2   = 6'd22;
    localparam step_t STEP_I_CTL_2    = 6'd23;
    localparam step_t STEP_I_DISP_ON  = 6'd24;
    localparam step_t STEP_I_GAP_2    = 6'd25;
    localparam step_t STEP_I_ADDR_3   = 6'd26;
    localparam step_t STEP_I_CTL_3    = 6'd27;
    localparam step_t STEP_I_CLEAR_1  = 6'd28;
    localparam step_t STEP_I_GAP_3    = 6'd29;
    localparam step_t STEP_I_ADDR_4   = 6'd30;
    localparam step_t STEP_I_CTL_4    = 6'd31;
    localparam step_t STEP_I_CLEAR_2  = 6'd32;
    localparam step_t STEP_I_END      = 6'd33;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_INIT   = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;

    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] STATUS_START_OK = 8'h08;
    localparam logic [7:0] STATUS_RSTRT_OK = 8'h10;
    localparam logic [7:0] STATUS_ADDR_ACK = 8'h18;
    localparam logic [7:0] STATUS_DATA_ACK = 8'h28;

    localparam logic [7:0] BYTE_CTL_CONT  = 8'h80;
    localparam logic [7:0] BYTE_DATA      = 8'h40;
    localparam logic [7:0] BYTE_ROW_TWO   = 8'hC0;
    localparam logic [7:0] BYTE_FUNC_SET  = 8'h38;
    localparam logic [7:0] BYTE_DISP_ON   = 8'h0C;
    localparam logic [7:0] BYTE_CLEAR     = 8'h01;
    localparam logic [7:0] ASCII_ZERO     = 8'd48;
    localparam logic [7:0] ASCII_BLANK    = 8'h20;

    localparam logic [8:0] WAIT_POWER_UP  = 9'd400;
    localparam logic [8:0] WAIT_CLEAR     = 9'd100;
    localparam logic [8:0] WAIT_SHORT     = 9'd1;

    localparam logic [1:0] LINE_TENTHS  = 2'd0;
    localparam logic [1:0] LINE_SECONDS = 2'd1;
    localparam logic [1:0] LINE_MINUTES = 2'd2;
    localparam logic [1:0] LINE_BLANK   = 2'd3;

    localparam logic [5:0] COL_TENTHS = 6'd8;
    localparam logic [5:0] COL_TENS   = 6'd9;
    localparam logic [5:0] COL_ONES   = 6'd10;

    localparam logic [63:0] LABEL_TENTHS  = "Tenths: ";
    localparam logic [63:0] LABEL_SECONDS = "Seconds:";
    localparam logic [63:0] LABEL_MINUTES = "Minutes:";
    localparam logic [63:0] LABEL_BLANK   = "        ";

    localparam logic REG_SLAVE_ADDRESS = 1'b0;
    localparam logic REG_REFRESH_TICKS = 1'b1;

    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h78;
    localparam logic [7:0] REFRESH_TICKS_RESET = 8'd5;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] data_byte;
        logic [8:0] wait_units;
    } bus_op_t;

    typedef struct packed {
        logic [1:0]        count;
        bus_op_t [2:0]     ops;
    } op_bundle_t;

    typedef struct packed {
        logic       valid;
        op_bundle_t bundle;
    } push_t;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] refresh_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/lcdsw_front.sv =====
// ============================================================================
// lcdsw_front
// Accepts events, keeps the stopwatch, display digits and sequence state, and
// turns each event into a bundle of up to three bus commands.
// ============================================================================
`default_nettype none

module lcdsw_front #(
    parameter int LINE_LENGTH = 20
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_mode,
    input  wire logic [7:0]           s_bus_status,
    input  wire lcdsw_pkg::cfg_t      cfg,
    output lcdsw_pkg::push_t          push,
    input  wire logic                 push_ready
);

    localparam int COL_W = $clog2(LINE_LENGTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_LENGTH - 1);

    function automatic lcdsw_pkg::bus_op_t mk_op(lcdsw_pkg::cmd_t c, logic [7:0] b,
                                                 logic [8:0] w);
        lcdsw_pkg::bus_op_t op;
        op.command    = c;
        op.data_byte  = b;
        op.wait_units = w;
        return op;
    endfunction

    function automatic logic [7:0] label_char(logic [1:0] line, logic [5:0] col);
        logic [63:0] text;
        logic [2:0]  k;
        unique case (line)
            lcdsw_pkg::LINE_TENTHS:  text = lcdsw_pkg::LABEL_TENTHS;
            lcdsw_pkg::LINE_SECONDS: text = lcdsw_pkg::LABEL_SECONDS;
            lcdsw_pkg::LINE_MINUTES: text = lcdsw_pkg::LABEL_MINUTES;
            default:                 text = lcdsw_pkg::LABEL_BLANK;
        endcase
        k = 3'd7 - col[2:0];
        if (col < 6'd8) begin
            return text[{k, 3'b000} +: 8];
        end
        return lcdsw_pkg::ASCII_BLANK;
    endfunction

    lcdsw_pkg::step_t   step_reg, step_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [15:0]        elapsed_reg, elapsed_next;
    logic [7:0]         tick_reg, tick_next;

    logic [3:0] tenth_reg, tenth_next;
    logic [3:0] sec_one_reg, sec_one_next;
    logic [2:0] sec_ten_reg, sec_ten_next;
    logic [3:0] min_one_reg, min_one_next;
    logic [3:0] min_ten_reg, min_ten_next;

    logic [7:0] disp_tenth_reg, disp_tenth_next;
    logic [7:0] disp_sec_ten_reg, disp_sec_ten_next;
    logic [7:0] disp_sec_one_reg, disp_sec_one_next;
    logic [7:0] disp_min_ten_reg, disp_min_ten_next;
    logic [7:0] disp_min_one_reg, disp_min_one_next;

    logic                    accept;
    logic                    tick_inc_wrap;
    logic [7:0]              tick_inc;
    logic                    refresh;
    logic                    status_ok;
    logic                    do_adv;
    lcdsw_pkg::step_t        eff_step;
    lcdsw_pkg::step_t        adv_step;
    logic [COL_W-1:0]        adv_col;
    lcdsw_pkg::op_bundle_t   adv;
    logic [1:0]              line_sel;
    logic [5:0]              col_ext;
    logic [7:0]              line_char;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    assign tick_inc  = tick_reg + 8'd1;
    assign refresh   = (s_mode == lcdsw_pkg::MODE_TICK) && (tick_inc >= cfg.refresh_ticks);
    assign tick_inc_wrap = (elapsed_reg == 16'hFFFF);
    assign status_ok = ((s_bus_status & lcdsw_pkg::STATUS_MASK) == lcdsw_pkg::STATUS_START_OK)
                    || ((s_bus_status & lcdsw_pkg::STATUS_MASK) == lcdsw_pkg::STATUS_RSTRT_OK)
                    || ((s_bus_status & lcdsw_pkg::STATUS_MASK) == lcdsw_pkg::STATUS_ADDR_ACK)
                    || ((s_bus_status & lcdsw_pkg::STATUS_MASK) == lcdsw_pkg::STATUS_DATA_ACK);

    always_comb begin
        unique case (s_mode)
            lcdsw_pkg::MODE_TICK: begin
                eff_step = lcdsw_pkg::STEP_START;
                do_adv   = refresh;
            end
            lcdsw_pkg::MODE_INIT: begin
                eff_step = lcdsw_pkg::STEP_INIT;
                do_adv   = 1'b1;
            end
            lcdsw_pkg::MODE_STATUS: begin
                eff_step = step_reg;
                do_adv   = status_ok;
            end
            default: begin
                eff_step = step_reg;
                do_adv   = 1'b0;
            end
        endcase
    end

    // character fetch from the line store: labels, blanks and the digit cells
    always_comb begin
        unique case (eff_step)
            lcdsw_pkg::STEP_LINE_ONE:   line_sel = lcdsw_pkg::LINE_TENTHS;
            lcdsw_pkg::STEP_LINE_THREE: line_sel = lcdsw_pkg::LINE_MINUTES;
            lcdsw_pkg::STEP_LINE_TWO:   line_sel = lcdsw_pkg::LINE_SECONDS;
            default:                    line_sel = lcdsw_pkg::LINE_BLANK;
        endcase
        col_ext = 6'(col_reg);
        priority if (line_sel == lcdsw_pkg::LINE_TENTHS && col_ext == lcdsw_pkg::COL_TENTHS) begin
            line_char = disp_tenth_reg;
        end else if (line_sel == lcdsw_pkg::LINE_SECONDS && col_ext == lcdsw_pkg::COL_TENS) begin
            line_char = disp_sec_ten_reg;
        end else if (line_sel == lcdsw_pkg::LINE_SECONDS && col_ext == lcdsw_pkg::COL_ONES) begin
            line_char = disp_sec_one_reg;
        end else if (line_sel == lcdsw_pkg::LINE_MINUTES && col_ext == lcdsw_pkg::COL_TENS) begin
            line_char = disp_min_ten_reg;
        end else if (line_sel == lcdsw_pkg::LINE_MINUTES && col_ext == lcdsw_pkg::COL_ONES) begin
            line_char = disp_min_one_reg;
        end else begin
            line_char = label_char(line_sel, col_ext);
        end
    end

    // one step of the command sequence
    always_comb begin
        adv      = '0;
        adv.count = 2'd1;
        adv_step = eff_step + 6'd1;
        adv_col  = col_reg;
        unique case (eff_step)
            lcdsw_pkg::STEP_START: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_START, 8'd0, 9'd0);
            end
            lcdsw_pkg::STEP_ADDR_A, lcdsw_pkg::STEP_ADDR_B, lcdsw_pkg::STEP_I_ADDR_1,
            lcdsw_pkg::STEP_I_ADDR_2, lcdsw_pkg::STEP_I_ADDR_3, lcdsw_pkg::STEP_I_ADDR_4: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, cfg.slave_address, 9'd0);
            end
            lcdsw_pkg::STEP_CTL_A, lcdsw_pkg::STEP_CTL_B, lcdsw_pkg::STEP_CTL_C,
            lcdsw_pkg::STEP_I_CTL_1, lcdsw_pkg::STEP_I_CTL_2, lcdsw_pkg::STEP_I_CTL_3,
            lcdsw_pkg::STEP_I_CTL_4: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_CTL_CONT, 9'd0);
            end
            lcdsw_pkg::STEP_DATA_A: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_DATA, 9'd0);
            end
            lcdsw_pkg::STEP_LINE_ONE, lcdsw_pkg::STEP_LINE_THREE,
            lcdsw_pkg::STEP_LINE_TWO, lcdsw_pkg::STEP_LINE_FOUR: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, line_char, 9'd0);
                if (col_reg == COL_LAST) begin
                    adv_col = '0;
                end else begin
                    adv_col  = col_reg + COL_W'(1);
                    adv_step = eff_step;
                end
            end
            lcdsw_pkg::STEP_RSTART: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_RSTART, 8'd0, 9'd0);
            end
            lcdsw_pkg::STEP_ROW_TWO: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_ROW_TWO, 9'd0);
            end
            lcdsw_pkg::STEP_DATA_B: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_DATA, 9'd0);
                adv_col    = '0;
            end
            lcdsw_pkg::STEP_STOP: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_STOP, 8'd0, 9'd0);
                adv_step   = lcdsw_pkg::STEP_START;
            end
            lcdsw_pkg::STEP_INIT: begin
                adv.count  = 2'd2;
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_WAIT, 8'd0, lcdsw_pkg::WAIT_POWER_UP);
                adv.ops[1] = mk_op(lcdsw_pkg::CMD_START, 8'd0, 9'd0);
            end
            lcdsw_pkg::STEP_I_FUNC: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_FUNC_SET, 9'd0);
            end
            lcdsw_pkg::STEP_I_DISP_ON: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_DISP_ON, 9'd0);
            end
            lcdsw_pkg::STEP_I_CLEAR_1, lcdsw_pkg::STEP_I_CLEAR_2: begin
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_CLEAR, 9'd0);
            end
            lcdsw_pkg::STEP_I_GAP_1, lcdsw_pkg::STEP_I_GAP_2: begin
                adv.count  = 2'd3;
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_STOP, 8'd0, 9'd0);
                adv.ops[1] = mk_op(lcdsw_pkg::CMD_WAIT, 8'd0, lcdsw_pkg::WAIT_SHORT);
                adv.ops[2] = mk_op(lcdsw_pkg::CMD_START, 8'd0, 9'd0);
            end
            lcdsw_pkg::STEP_I_GAP_3: begin
                adv.count  = 2'd3;
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_STOP, 8'd0, 9'd0);
                adv.ops[1] = mk_op(lcdsw_pkg::CMD_WAIT, 8'd0, lcdsw_pkg::WAIT_CLEAR);
                adv.ops[2] = mk_op(lcdsw_pkg::CMD_START, 8'd0, 9'd0);
            end
            lcdsw_pkg::STEP_I_END: begin
                adv.count  = 2'd2;
                adv.ops[0] = mk_op(lcdsw_pkg::CMD_STOP, 8'd0, 9'd0);
                adv.ops[1] = mk_op(lcdsw_pkg::CMD_WAIT, 8'd0, lcdsw_pkg::WAIT_SHORT);
                adv_step   = lcdsw_pkg::STEP_START;
            end
            default: begin
                adv.count = 2'd0;
                adv_step  = lcdsw_pkg::STEP_START;
            end
        endcase
    end

    assign push.valid  = accept && do_adv && (adv.count != 2'd0);
    assign push.bundle = adv;

    // stopwatch digits, carried digit by digit; all cleared when elapsed wraps
    always_comb begin
        elapsed_next = elapsed_reg + 16'd1;
        tenth_next   = tenth_reg;
        sec_one_next = sec_one_reg;
        sec_ten_next = sec_ten_reg;
        min_one_next = min_one_reg;
        min_ten_next = min_ten_reg;
        if (tick_inc_wrap) begin
            tenth_next   = '0;
            sec_one_next = '0;
            sec_ten_next = '0;
            min_one_next = '0;
            min_ten_next = '0;
        end else if (tenth_reg != 4'd9) begin
            tenth_next = tenth_reg + 4'd1;
        end else begin
            tenth_next = '0;
            if (sec_one_reg != 4'd9) begin
                sec_one_next = sec_one_reg + 4'd1;
            end else begin
                sec_one_next = '0;
                if (sec_ten_reg != 3'd5) begin
                    sec_ten_next = sec_ten_reg + 3'd1;
                end else begin
                    sec_ten_next = '0;
                    if (min_one_reg != 4'd9) begin
                        min_one_next = min_one_reg + 4'd1;
                    end else begin
                        min_one_next = '0;
                        min_ten_next = min_ten_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        tick_next         = tick_reg;
        step_next         = step_reg;
        col_next          = col_reg;
        disp_tenth_next   = disp_tenth_reg;
        disp_sec_ten_next = disp_sec_ten_reg;
        disp_sec_one_next = disp_sec_one_reg;
        disp_min_ten_next = disp_min_ten_reg;
        disp_min_one_next = disp_min_one_reg;
        if (s_mode == lcdsw_pkg::MODE_TICK) begin
            tick_next = refresh ? 8'd0 : tick_inc;
        end
        if (refresh) begin
            disp_tenth_next   = lcdsw_pkg::ASCII_ZERO + 8'(tenth_next);
            disp_sec_ten_next = lcdsw_pkg::ASCII_ZERO + 8'(sec_ten_next);
            disp_sec_one_next = lcdsw_pkg::ASCII_ZERO + 8'(sec_one_next);
            disp_min_ten_next = lcdsw_pkg::ASCII_ZERO + 8'(min_ten_next);
            disp_min_one_next = lcdsw_pkg::ASCII_ZERO + 8'(min_one_next);
        end
        if (do_adv) begin
            step_next = adv_step;
            col_next  = adv_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg         <= lcdsw_pkg::STEP_START;
            col_reg          <= '0;
            elapsed_reg      <= '0;
            tick_reg         <= '0;
            tenth_reg        <= '0;
            sec_one_reg      <= '0;
            sec_ten_reg      <= '0;
            min_one_reg      <= '0;
            min_ten_reg      <= '0;
            disp_tenth_reg   <= lcdsw_pkg::ASCII_BLANK;
            disp_sec_ten_reg <= lcdsw_pkg::ASCII_BLANK;
            disp_sec_one_reg <= lcdsw_pkg::ASCII_BLANK;
            disp_min_ten_reg <= lcdsw_pkg::ASCII_BLANK;
            disp_min_one_reg <= lcdsw_pkg::ASCII_BLANK;
        end else if (accept) begin
            step_reg         <= step_next;
            col_reg          <= col_next;
            tick_reg         <= tick_next;
            disp_tenth_reg   <= disp_tenth_next;
            disp_sec_ten_reg <= disp_sec_ten_next;
            disp_sec_one_reg <= disp_sec_one_next;
            disp_min_ten_reg <= disp_min_ten_next;
            disp_min_one_reg <= disp_min_one_next;
            if (s_mode == lcdsw_pkg::MODE_TICK) begin
                elapsed_reg <= elapsed_next;
                tenth_reg   <= tenth_next;
                sec_one_reg <= sec_one_next;
                sec_ten_reg <= sec_ten_next;
                min_one_reg <= min_one_next;
                min_ten_reg <= min_ten_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcdsw_queue.sv =====
// ============================================================================
// lcdsw_queue
// Small register queue of command bundles between the front and back ends.
// ============================================================================
`default_nettype none

module lcdsw_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lcdsw_pkg::push_t       push,
    output logic                        push_ready,
    output logic                        pop_valid,
    output lcdsw_pkg::op_bundle_t       pop_data,
    input  wire logic                   pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lcdsw_pkg::op_bundle_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.bundle;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcdsw_back.sv =====
// ============================================================================
// lcdsw_back
// Unpacks each command bundle into single bus commands, one per cycle unless
// m_ready stalls, into the output register; marks each bundle's last command.
// ============================================================================
`default_nettype none

module lcdsw_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   pop_valid,
    input  wire lcdsw_pkg::op_bundle_t  pop_data,
    output logic                        pop_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [2:0]                  m_command,
    output logic [7:0]                  m_data_byte,
    output logic [8:0]                  m_wait_units,
    output logic                        m_last
);

    logic [1:0]          idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    lcdsw_pkg::bus_op_t  m_op_reg;
    logic                m_last_reg;
    logic                load;
    logic                final_op;

    assign load      = pop_valid && (!m_valid_reg || m_ready);
    assign final_op  = (idx_reg == pop_data.count - 2'd1);
    assign pop_ready = load && final_op;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            idx_next     = final_op ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_op_reg   <= pop_data.ops[idx_reg];
            m_last_reg <= final_op;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_command    = m_op_reg.command;
    assign m_data_byte  = m_op_reg.data_byte;
    assign m_wait_units = m_op_reg.wait_units;
    assign m_last       = m_last_reg;

`ifndef SYNTHESIS
    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_ready |-> pop_valid)
        else $error("bundle released while queue is empty");

    a_no_empty_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_valid |-> (pop_data.count != 2'd0))
        else $error("empty bundle in queue");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_valid |-> (idx_reg < pop_data.count))
        else $error("command index beyond bundle size");

    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_ready |=> (idx_reg == 2'd0))
        else $error("command index not restarted after bundle");
`endif

endmodule

`default_nettype wire

// ===== sv/i2c_lcd_stopwatch_refresh_sequencer.sv =====
// ============================================================================
// i2c_lcd_stopwatch_refresh_sequencer
// Stopwatch display sequencer: turns timer ticks, init requests and bus
// status events into I2C master commands for a 4-line character display.
//
//   port group   direction  handshake          payload
//   s_*          in         s_valid / s_ready  s_mode, s_bus_status
//   m_*          out        m_valid / m_ready  m_command, m_data_byte,
//                                              m_wait_units, m_last
//   APB          in         psel/penable       slave_address, refresh_ticks
//
// One request is taken per cycle while the bundle queue has room; each request
// yields zero to three commands, which leave the output register one per cycle
// while m_ready is high. A request's first command passes through the bundle
// queue and then the output register before it is offered.
// Queue depth (QUEUE_DEPTH bundles) sets how far the front runs ahead.
// Synchronous active-low reset restores the counters, digits and registers.
// ============================================================================
`default_nettype none

module i2c_lcd_stopwatch_refresh_sequencer #(
    parameter int LINE_LENGTH = 20,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_bus_status,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_command,
    output logic [7:0]       m_data_byte,
    output logic [8:0]       m_wait_units,
    output logic             m_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]             slave_address_reg;
    logic [7:0]             refresh_ticks_reg;
    logic                   cfg_write;
    lcdsw_pkg::cfg_t        cfg;
    lcdsw_pkg::push_t       push;
    logic                   push_ready;
    logic                   pop_valid;
    lcdsw_pkg::op_bundle_t  pop_data;
    logic                   pop_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= lcdsw_pkg::SLAVE_ADDRESS_RESET;
            refresh_ticks_reg <= lcdsw_pkg::REFRESH_TICKS_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == lcdsw_pkg::REG_SLAVE_ADDRESS) begin
                slave_address_reg <= pwdata[7:0];
            end else begin
                refresh_ticks_reg <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            lcdsw_pkg::REG_SLAVE_ADDRESS: prdata = {24'd0, slave_address_reg};
            lcdsw_pkg::REG_REFRESH_TICKS: prdata = {24'd0, refresh_ticks_reg};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.slave_address = slave_address_reg;
    assign cfg.refresh_ticks = refresh_ticks_reg;

    lcdsw_front #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_bus_status (s_bus_status),
        .cfg          (cfg),
        .push         (push),
        .push_ready   (push_ready)
    );

    lcdsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    lcdsw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_data     (pop_data),
        .pop_ready    (pop_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_command    (m_command),
        .m_data_byte  (m_data_byte),
        .m_wait_units (m_wait_units),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

// ===== verif/lcd_command_checker.sv =====
// ----------------------------------------------------------------------------
// Display command checker
// Watches the request, command and register ports of the stopwatch display
// sequencer. It tracks its own copy of the sequencer state and line store,
// works out the bus commands that each accepted request should cause, and
// compares every command taken at the output with the oldest one still due.
// ----------------------------------------------------------------------------
module lcd_command_checker #(
    parameter int LINE_LENGTH = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_bus_status,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_command,
    input  wire logic [7:0]  m_data_byte,
    input  wire logic [8:0]  m_wait_units,
    input  wire logic        m_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_COUNT        = 4;
    localparam int TENTHS_PER_MINUTE = 600;
    localparam int TENTHS_PER_SECOND = 10;

    typedef struct packed {
        lcdsw_pkg::cmd_t command;
        logic [7:0]      data_byte;
        logic [8:0]      wait_units;
        logic            last;
    } lcd_cmd_t;

    lcd_cmd_t         bus_cmd_queue[$];
    lcd_cmd_t         request_cmds[$];
    logic [7:0]       char_store[LINE_COUNT*LINE_LENGTH];
    logic [7:0]       slave_addr;
    logic [7:0]       refresh_period;
    lcdsw_pkg::step_t seq_step;
    logic [5:0]       column;
    logic [15:0]      elapsed;
    logic [7:0]       tick_cnt;
    int               errors;

    task automatic clear_display_state();
        int i;
        slave_addr     = lcdsw_pkg::SLAVE_ADDRESS_RESET;
        refresh_period = lcdsw_pkg::REFRESH_TICKS_RESET;
        seq_step       = lcdsw_pkg::STEP_START;
        column         = '0;
        elapsed        = '0;
        tick_cnt       = '0;
        errors         = 0;
        for (i = 0; i < LINE_COUNT*LINE_LENGTH; i++) char_store[i] = lcdsw_pkg::ASCII_BLANK;
        for (i = 0; i < 8 && i < LINE_LENGTH; i++) begin
            char_store[lcdsw_pkg::LINE_TENTHS*LINE_LENGTH + i] =
                lcdsw_pkg::LABEL_TENTHS[63-8*i -: 8];
            char_store[lcdsw_pkg::LINE_SECONDS*LINE_LENGTH + i] =
                lcdsw_pkg::LABEL_SECONDS[63-8*i -: 8];
            char_store[lcdsw_pkg::LINE_MINUTES*LINE_LENGTH + i] =
                lcdsw_pkg::LABEL_MINUTES[63-8*i -: 8];
        end
    endtask

    task automatic add_cmd(input lcdsw_pkg::cmd_t cmd, input logic [7:0] data,
                           input logic [8:0] units);
        lcd_cmd_t op;
        op.command    = cmd;
        op.data_byte  = data;
        op.wait_units = units;
        op.last       = 1'b0;
        if (request_cmds.size() < 3) request_cmds.push_back(op);
    endtask

    task automatic send_line_char(input logic [1:0] line, output lcdsw_pkg::step_t following);
        logic [7:0] ch;
        ch = lcdsw_pkg::ASCII_BLANK;
        if (column < LINE_LENGTH) ch = char_store[line*LINE_LENGTH + column];
        add_cmd(lcdsw_pkg::CMD_SEND, ch, '0);
        if (int'(column) + 1 < LINE_LENGTH) begin
            column    = column + 1'b1;
            following = seq_step;
        end else begin
            column    = '0;
            following = seq_step + 1'b1;
        end
    endtask

    task automatic advance_sequence();
        lcdsw_pkg::step_t next_step;
        next_step = seq_step + 1'b1;
        case (seq_step)
            lcdsw_pkg::STEP_START: add_cmd(lcdsw_pkg::CMD_START, '0, '0);
            lcdsw_pkg::STEP_ADDR_A, lcdsw_pkg::STEP_ADDR_B, lcdsw_pkg::STEP_I_ADDR_1,
            lcdsw_pkg::STEP_I_ADDR_2, lcdsw_pkg::STEP_I_ADDR_3, lcdsw_pkg::STEP_I_ADDR_4:
                add_cmd(lcdsw_pkg::CMD_SEND, slave_addr, '0);
            lcdsw_pkg::STEP_CTL_A, lcdsw_pkg::STEP_CTL_B, lcdsw_pkg::STEP_CTL_C,
            lcdsw_pkg::STEP_I_CTL_1, lcdsw_pkg::STEP_I_CTL_2, lcdsw_pkg::STEP_I_CTL_3,
            lcdsw_pkg::STEP_I_CTL_4:
                add_cmd(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_CTL_CONT, '0);
            lcdsw_pkg::STEP_DATA_A: add_cmd(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_DATA, '0);
            lcdsw_pkg::STEP_LINE_ONE:   send_line_char(lcdsw_pkg::LINE_TENTHS, next_step);
            lcdsw_pkg::STEP_LINE_THREE: send_line_char(lcdsw_pkg::LINE_MINUTES, next_step);
            lcdsw_pkg::STEP_RSTART: add_cmd(lcdsw_pkg::CMD_RSTART, '0, '0);
            lcdsw_pkg::STEP_ROW_TWO:
                add_cmd(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_ROW_TWO, '0);
            lcdsw_pkg::STEP_DATA_B: begin
                add_cmd(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_DATA, '0);
                column = '0;
            end
            lcdsw_pkg::STEP_LINE_TWO:  send_line_char(lcdsw_pkg::LINE_SECONDS, next_step);
            lcdsw_pkg::STEP_LINE_FOUR: send_line_char(lcdsw_pkg::LINE_BLANK, next_step);
            lcdsw_pkg::STEP_STOP: begin
                add_cmd(lcdsw_pkg::CMD_STOP, '0, '0);
                next_step = lcdsw_pkg::STEP_START;
            end
            lcdsw_pkg::STEP_INIT: begin
                add_cmd(lcdsw_pkg::CMD_WAIT, '0, lcdsw_pkg::WAIT_POWER_UP);
                add_cmd(lcdsw_pkg::CMD_START, '0, '0);
            end
            lcdsw_pkg::STEP_I_FUNC:
                add_cmd(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_FUNC_SET, '0);
            lcdsw_pkg::STEP_I_DISP_ON:
                add_cmd(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_DISP_ON, '0);
            lcdsw_pkg::STEP_I_CLEAR_1, lcdsw_pkg::STEP_I_CLEAR_2:
                add_cmd(lcdsw_pkg::CMD_SEND, lcdsw_pkg::BYTE_CLEAR, '0);
            lcdsw_pkg::STEP_I_GAP_1, lcdsw_pkg::STEP_I_GAP_2: begin
                add_cmd(lcdsw_pkg::CMD_STOP, '0, '0);
                add_cmd(lcdsw_pkg::CMD_WAIT, '0, lcdsw_pkg::WAIT_SHORT);
                add_cmd(lcdsw_pkg::CMD_START, '0, '0);
            end
            lcdsw_pkg::STEP_I_GAP_3: begin
                add_cmd(lcdsw_pkg::CMD_STOP, '0, '0);
                add_cmd(lcdsw_pkg::CMD_WAIT, '0, lcdsw_pkg::WAIT_CLEAR);
                add_cmd(lcdsw_pkg::CMD_START, '0, '0);
            end
            lcdsw_pkg::STEP_I_END: begin
                add_cmd(lcdsw_pkg::CMD_STOP, '0, '0);
                add_cmd(lcdsw_pkg::CMD_WAIT, '0, lcdsw_pkg::WAIT_SHORT);
                next_step = lcdsw_pkg::STEP_START;
            end
            default: next_step = lcdsw_pkg::STEP_START;
        endcase
        seq_step = next_step;
    endtask

    task automatic put_digit(input logic [1:0] line, input logic [5:0] col, input int value);
        if (col < LINE_LENGTH) char_store[line*LINE_LENGTH + col] = value[7:0];
    endtask

    task automatic count_tick();
        int mins, rest, secs, tenths;
        elapsed  = elapsed + 1'b1;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= refresh_period) begin
            mins   = elapsed / TENTHS_PER_MINUTE;
            rest   = elapsed - mins * TENTHS_PER_MINUTE;
            secs   = rest / TENTHS_PER_SECOND;
            tenths = rest % TENTHS_PER_SECOND;
            put_digit(lcdsw_pkg::LINE_TENTHS, lcdsw_pkg::COL_TENTHS,
                      tenths + lcdsw_pkg::ASCII_ZERO);
            put_digit(lcdsw_pkg::LINE_SECONDS, lcdsw_pkg::COL_TENS,
                      secs / 10 + lcdsw_pkg::ASCII_ZERO);
            put_digit(lcdsw_pkg::LINE_SECONDS, lcdsw_pkg::COL_ONES,
                      secs % 10 + lcdsw_pkg::ASCII_ZERO);
            put_digit(lcdsw_pkg::LINE_MINUTES, lcdsw_pkg::COL_TENS,
                      mins / 10 + lcdsw_pkg::ASCII_ZERO);
            put_digit(lcdsw_pkg::LINE_MINUTES, lcdsw_pkg::COL_ONES,
                      mins % 10 + lcdsw_pkg::ASCII_ZERO);
            tick_cnt = '0;
            seq_step = lcdsw_pkg::STEP_START;
            advance_sequence();
        end
    endtask

    task automatic predict_bus_cmds(input logic [1:0] mode, input logic [7:0] status);
        logic [7:0] code;
        lcd_cmd_t   op;
        int         i;
        request_cmds.delete();
        code = status & lcdsw_pkg::STATUS_MASK;
        case (mode)
            lcdsw_pkg::MODE_TICK: count_tick();
            lcdsw_pkg::MODE_INIT: begin
                seq_step = lcdsw_pkg::STEP_INIT;
                advance_sequence();
            end
            lcdsw_pkg::MODE_STATUS: begin
                if (code == lcdsw_pkg::STATUS_START_OK || code == lcdsw_pkg::STATUS_RSTRT_OK ||
                    code == lcdsw_pkg::STATUS_ADDR_ACK || code == lcdsw_pkg::STATUS_DATA_ACK)
                    advance_sequence();
            end
            default: ;
        endcase
        for (i = 0; i < request_cmds.size(); i++) begin
            op      = request_cmds[i];
            op.last = (i == request_cmds.size() - 1);
            bus_cmd_queue.push_back(op);
        end
    endtask

    task automatic check_field(input string field, input logic [8:0] want, input logic [8:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    task automatic check_bus_cmd();
        lcd_cmd_t want;
        if (bus_cmd_queue.size() == 0) begin
            errors++;
            $display("%0t: command expected none, got command %0d byte %0d wait %0d last %0d",
                     $time, m_command, m_data_byte, m_wait_units, m_last);
        end else begin
            want = bus_cmd_queue.pop_front();
            check_field("command", want.command, m_command);
            check_field("data_byte", want.data_byte, m_data_byte);
            check_field("wait_units", want.wait_units, m_wait_units);
            check_field("last", want.last, m_last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_display_state();
            bus_cmd_queue.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == lcdsw_pkg::REG_SLAVE_ADDRESS) slave_addr = pwdata[7:0];
                else refresh_period = pwdata[7:0];
            end
            if (m_valid && m_ready) check_bus_cmd();
            if (s_valid && s_ready) predict_bus_cmds(s_mode, s_bus_status);
            mismatches  <= errors;
            outstanding <= bus_cmd_queue.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Stopwatch display sequencer testbench
// Drives ticks, init requests and bus status events into the sequencer with
// random gaps and output stalls, walks a complete refresh sequence and random
// stretches of both sequences, and changes the registers between phases. The
// checker beside the block predicts and compares every command.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LENGTH      = 20;
    localparam int IDLE_PERCENT     = 13;
    localparam int DRAIN_CYCLES     = 16;
    localparam int STALL_LIMIT      = 4000;
    localparam int RANDOM_REQUESTS  = 300;
    localparam int REFRESH_WALK_LEN = 4*LINE_LENGTH + 10;
    localparam int INIT_WALK_LEN    = 16;

    localparam logic [1:0] MODE_UNUSED      = 2'd3;
    localparam logic [7:0] STATUS_BUS_ERROR = 8'h00;
    localparam logic [7:0] STATUS_NO_INFO   = 8'hF8;
    localparam logic [7:0] STATUS_DATA_NACK = 8'h30;
    localparam logic [7:0] STATUS_ALL_ONES  = 8'hFF;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic [1:0]  s_mode       = lcdsw_pkg::MODE_TICK;
    logic [7:0]  s_bus_status = '0;
    logic        m_ready      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_command;
    logic [7:0]  m_data_byte;
    logic [8:0]  m_wait_units;
    logic        m_last;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;
    int          requests_sent     = 0;
    int          quiet_cycles      = 0;
    bit          no_idle           = 1'b0;

    always #10 aclk = ~aclk;

    i2c_lcd_stopwatch_refresh_sequencer #(.LINE_LENGTH(LINE_LENGTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_bus_status(s_bus_status),
        .m_valid(m_valid), .m_ready(m_ready), .m_command(m_command),
        .m_data_byte(m_data_byte), .m_wait_units(m_wait_units), .m_last(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lcd_command_checker #(.LINE_LENGTH(LINE_LENGTH)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_bus_status(s_bus_status),
        .m_valid(m_valid), .m_ready(m_ready), .m_command(m_command),
        .m_data_byte(m_data_byte), .m_wait_units(m_wait_units), .m_last(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .mismatches(mismatches), .outstanding(outstanding)
    );

    always @(posedge aclk) m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pwrite))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] success_status();
        logic [7:0] code;
        case ($urandom_range(3))
            0:       code = lcdsw_pkg::STATUS_START_OK;
            1:       code = lcdsw_pkg::STATUS_RSTRT_OK;
            2:       code = lcdsw_pkg::STATUS_ADDR_ACK;
            default: code = lcdsw_pkg::STATUS_DATA_ACK;
        endcase
        return code | 8'($urandom_range(7));
    endfunction

    task automatic send_request(input logic [1:0] mode, input logic [7:0] status);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_bus_status <= status;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic send_noise();
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    task automatic walk_sequence(input int steps);
        repeat (steps) begin
            if ($urandom_range(99) < 8) send_noise();
            else send_request(lcdsw_pkg::MODE_STATUS, success_status());
        end
    endtask

    // hold off until every command has come and the block has gone quiet
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic index, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic full_refresh(input logic [7:0] address);
        settle_block();
        write_register(lcdsw_pkg::REG_SLAVE_ADDRESS, address);
        write_register(lcdsw_pkg::REG_REFRESH_TICKS, 8'd0);
        send_request(lcdsw_pkg::MODE_TICK, 8'($urandom_range(255)));
        repeat (REFRESH_WALK_LEN) send_request(lcdsw_pkg::MODE_STATUS, success_status());
        settle_block();
        write_register(lcdsw_pkg::REG_REFRESH_TICKS, 8'd255);
    endtask

    initial begin
        int random_start, pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(MODE_UNUSED, STATUS_ALL_ONES);
        send_request(lcdsw_pkg::MODE_STATUS, STATUS_BUS_ERROR);
        send_request(lcdsw_pkg::MODE_STATUS, STATUS_ALL_ONES);
        send_request(lcdsw_pkg::MODE_STATUS, lcdsw_pkg::STATUS_START_OK | 8'h07);
        send_request(lcdsw_pkg::MODE_STATUS, lcdsw_pkg::STATUS_ADDR_ACK);
        send_request(lcdsw_pkg::MODE_INIT, STATUS_ALL_ONES);
        repeat (4) send_request(lcdsw_pkg::MODE_STATUS, lcdsw_pkg::STATUS_DATA_ACK);
        repeat (5) send_request(lcdsw_pkg::MODE_TICK, STATUS_BUS_ERROR);
        send_request(lcdsw_pkg::MODE_STATUS, lcdsw_pkg::STATUS_RSTRT_OK);

        settle_block();
        write_register(lcdsw_pkg::REG_SLAVE_ADDRESS, 8'hFF);
        write_register(lcdsw_pkg::REG_REFRESH_TICKS, 8'd0);
        send_request(lcdsw_pkg::MODE_TICK, STATUS_ALL_ONES);
        send_request(lcdsw_pkg::MODE_STATUS, lcdsw_pkg::STATUS_START_OK);
        send_request(lcdsw_pkg::MODE_INIT, STATUS_BUS_ERROR);
        send_request(lcdsw_pkg::MODE_STATUS, lcdsw_pkg::STATUS_ADDR_ACK);
        send_request(lcdsw_pkg::MODE_STATUS, STATUS_DATA_NACK);

        settle_block();
        write_register(lcdsw_pkg::REG_SLAVE_ADDRESS, 8'h00);
        write_register(lcdsw_pkg::REG_REFRESH_TICKS, 8'd255);
        repeat (2) send_request(lcdsw_pkg::MODE_TICK, STATUS_NO_INFO);
        send_request(lcdsw_pkg::MODE_STATUS, lcdsw_pkg::STATUS_ADDR_ACK);
        send_request(lcdsw_pkg::MODE_STATUS, STATUS_NO_INFO);

        full_refresh(8'($urandom_range(255)));

        settle_block();
        write_register(lcdsw_pkg::REG_SLAVE_ADDRESS, 8'($urandom_range(255)));
        write_register(lcdsw_pkg::REG_REFRESH_TICKS, 8'($urandom_range(1, 6)));
        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_REQUESTS) begin
            no_idle = (requests_sent - random_start) < 80;
            pick = $urandom_range(99);
            if (pick < 40) begin
                repeat ($urandom_range(1, 4))
                    send_request(lcdsw_pkg::MODE_TICK, 8'($urandom_range(255)));
                walk_sequence($urandom_range(1, REFRESH_WALK_LEN + 4));
            end else if (pick < 65) begin
                send_request(lcdsw_pkg::MODE_INIT, 8'($urandom_range(255)));
                walk_sequence($urandom_range(1, INIT_WALK_LEN + 2));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) send_noise();
            end else begin
                settle_block();
                write_register(lcdsw_pkg::REG_SLAVE_ADDRESS, 8'($urandom_range(255)));
                if ($urandom_range(99) < 70)
                    write_register(lcdsw_pkg::REG_REFRESH_TICKS, 8'($urandom_range(0, 6)));
                else
                    write_register(lcdsw_pkg::REG_REFRESH_TICKS, 8'($urandom_range(7, 255)));
            end
        end
        no_idle = 1'b0;

        settle_block();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lcdsw_pkg.sv
sv/lcdsw_front.sv
sv/lcdsw_queue.sv
sv/lcdsw_back.sv
sv/i2c_lcd_stopwatch_refresh_sequencer.sv
verif/lcd_command_checker.sv
verif/tb.sv
